// File: rtl/core/exlex_pkg.sv
// Shared types, character codes, token kinds and character classes of the expression lexer.
`default_nettype none

package exlex_pkg;

	// Token kinds as they appear on the result channel.
	localparam logic [3:0] KIND_NUMBER = 4'd0;
	localparam logic [3:0] KIND_IDENT  = 4'd1;
	localparam logic [3:0] KIND_PLUS   = 4'd2;
	localparam logic [3:0] KIND_MINUS  = 4'd3;
	localparam logic [3:0] KIND_STAR   = 4'd4;
	localparam logic [3:0] KIND_SLASH  = 4'd5;
	localparam logic [3:0] KIND_CARET  = 4'd6;
	localparam logic [3:0] KIND_LPAREN = 4'd7;
	localparam logic [3:0] KIND_RPAREN = 4'd8;
	localparam logic [3:0] KIND_COMMA  = 4'd9;
	localparam logic [3:0] KIND_END    = 4'd10;
	localparam logic [3:0] KIND_ERROR  = 4'd11;

	// ASCII codes the scanner tests against.
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_CR         = 8'h0D;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_LPAREN     = 8'h28;
	localparam logic [7:0] CH_RPAREN     = 8'h29;
	localparam logic [7:0] CH_STAR       = 8'h2A;
	localparam logic [7:0] CH_PLUS       = 8'h2B;
	localparam logic [7:0] CH_COMMA      = 8'h2C;
	localparam logic [7:0] CH_MINUS      = 8'h2D;
	localparam logic [7:0] CH_DOT        = 8'h2E;
	localparam logic [7:0] CH_SLASH      = 8'h2F;
	localparam logic [7:0] CH_DIGIT_0    = 8'h30;
	localparam logic [7:0] CH_DIGIT_9    = 8'h39;
	localparam logic [7:0] CH_UPPER_A    = 8'h41;
	localparam logic [7:0] CH_UPPER_E    = 8'h45;
	localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
	localparam logic [7:0] CH_CARET      = 8'h5E;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_LOWER_A    = 8'h61;
	localparam logic [7:0] CH_LOWER_E    = 8'h65;
	localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

	// One character can produce at most this many tokens.
	localparam int MAX_TOKENS = 3;
	localparam int FIFO_DEPTH = 8;
	localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
	localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
	} char_t;

	typedef struct packed {
		logic [3:0]  token_kind;
		logic [15:0] token_start;
		logic [15:0] token_length;
		logic        last_of_run;
	} token_t;

	// Tokens produced by one character, packed from slot zero upward.
	typedef struct packed {
		logic [1:0]                  count;
		token_t [MAX_TOKENS-1:0]     tok;
	} push_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[CH_DIGIT_0:CH_DIGIT_9]};
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return c inside {[CH_LOWER_A:CH_LOWER_Z], [CH_UPPER_A:CH_UPPER_Z]};
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c inside {CH_SPACE, [CH_TAB:CH_CR]};
	endfunction

	function automatic logic is_ident_tail(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE);
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET,
			CH_LPAREN, CH_RPAREN, CH_COMMA};
	endfunction

	function automatic logic [3:0] op_kind(input logic [7:0] c);
		logic [3:0] k;
		case (c)
			CH_PLUS:   k = KIND_PLUS;
			CH_MINUS:  k = KIND_MINUS;
			CH_STAR:   k = KIND_STAR;
			CH_SLASH:  k = KIND_SLASH;
			CH_CARET:  k = KIND_CARET;
			CH_LPAREN: k = KIND_LPAREN;
			CH_RPAREN: k = KIND_RPAREN;
			CH_COMMA:  k = KIND_COMMA;
			default:   k = KIND_ERROR;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/expression_lexer.sv
// Top level of the streaming arithmetic expression lexer.
// Usage:
//   The char channel takes one source byte per transaction with is_last set on the
//   final byte of a source. The token channel delivers tokens as kind, start and
//   length, with last_of_run set on the final token a byte produced; the final byte
//   always yields an end token.
//   A byte sits in the input register, where the scan logic decides its tokens and
//   writes them into an eight-entry token queue, whose head is offered on the token port.
//   Throughput is one byte per cycle while the queue has room. A byte may produce up
//   to three tokens and the token port drains one per cycle; the input register
//   advances only while the queue holds five tokens or fewer, so token-dense input
//   runs at the token rate.
//   When the receiver stalls, the queue fills and char_stall rises; no token is lost.
//   Reset empties the queue and input register and returns the scanner to position
//   zero, between tokens. After the final byte of a source the scanner returns to
//   that same state on its own. Positions saturate at 2**POSITION_BITS - 1.
`default_nettype none

module expression_lexer import exlex_pkg::*; #(
	parameter int POSITION_BITS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  char_valid,
	output logic       char_stall,
	input  wire char_t char_item,
	output logic       token_valid,
	input  wire logic  token_stall,
	output token_t     token_item
);

	push_t push;
	logic  room;

	exlex_scan #(
		.POSITION_BITS(POSITION_BITS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item),
		.room       (room),
		.push       (push)
	);

	exlex_tok_fifo u_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.room        (room),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_item  (token_item)
	);

endmodule

`default_nettype wire

// File: rtl/core/exlex_scan.sv
// Input register, scan state and the per-character token decision of the expression lexer.
`default_nettype none

module exlex_scan import exlex_pkg::*; #(
	parameter int POSITION_BITS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  char_valid,
	output logic       char_stall,
	input  wire char_t char_item,
	input  wire logic  room,
	output push_t      push
);

	localparam int NUM_CAND = 5;

	typedef enum logic [8:0] {
		M_IDLE     = 9'b000000001,
		M_INT      = 9'b000000010,
		M_DOT_INT  = 9'b000000100,
		M_DOT_LEAD = 9'b000001000,
		M_FRAC     = 9'b000010000,
		M_EXP      = 9'b000100000,
		M_EXP_TAIL = 9'b001000000,
		M_IDENT    = 9'b010000000,
		M_ERROR    = 9'b100000000
	} mode_t;

	typedef logic [POSITION_BITS-1:0] pos_t;

	logic  valid_s1;
	char_t item_s1;
	mode_t mode_q, mode_d, m1, bt_mode;
	pos_t  pos_q, pos_d, tb_q, tb_d, tb1, bt_tb, p, pm1, posn, posnm1;
	logic  adv, load, bt_v;
	logic  [7:0] c;
	logic  [3:0] bt_kind;
	token_t bt_tok;
	token_t [NUM_CAND-1:0] cand;
	logic  [NUM_CAND-1:0] cand_v;
	token_t [MAX_TOKENS-1:0] slots;
	logic  [1:0] n;

	function automatic logic [15:0] pos16(input pos_t v);
		logic [32:0] w;
		w = 33'(v);
		return w[15:0];
	endfunction

	function automatic pos_t dec_floor(input pos_t v);
		return (v != '0) ? v - pos_t'(1) : '0;
	endfunction

	// Token covering [s, e), length saturated to the field width.
	function automatic token_t mk_span(input logic [3:0] k, input pos_t s, input pos_t e);
		pos_t        d;
		logic [32:0] dw;
		token_t      t;
		d  = (e >= s) ? e - s : '0;
		dw = 33'(d);
		t.token_kind   = k;
		t.token_start  = pos16(s);
		t.token_length = (dw > 33'h0FFFF) ? 16'hFFFF : dw[15:0];
		t.last_of_run  = 1'b0;
		return t;
	endfunction

	function automatic token_t mk_one(input logic [3:0] k, input pos_t s);
		token_t t;
		t.token_kind   = k;
		t.token_start  = pos16(s);
		t.token_length = 16'd1;
		t.last_of_run  = 1'b0;
		return t;
	endfunction

	assign adv        = valid_s1 && room;
	assign char_stall = valid_s1 && !room;
	assign load       = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= char_item;
		end
	end

	always_comb begin
		c = item_s1.char_code;
		p = pos_q;
		pm1 = dec_floor(p);

		// What a character does when it arrives between tokens.
		bt_v    = 1'b0;
		bt_kind = KIND_ERROR;
		bt_mode = M_IDLE;
		bt_tb   = p;
		if (is_space(c)) begin
			bt_tb = tb_q;
		end else if (is_digit(c)) begin
			bt_mode = M_INT;
		end else if (c == CH_DOT) begin
			bt_mode = M_DOT_LEAD;
		end else if (is_alpha(c) || c == CH_UNDERSCORE) begin
			bt_mode = M_IDENT;
		end else if (is_op(c)) begin
			bt_v    = 1'b1;
			bt_kind = op_kind(c);
		end else begin
			bt_v    = 1'b1;
			bt_mode = M_ERROR;
		end
		bt_tok = mk_one(bt_kind, p);

		cand   = '0;
		cand_v = '0;
		m1     = mode_q;
		tb1    = tb_q;
		case (mode_q)
			M_INT, M_FRAC: begin
				if (is_digit(c)) begin
					m1 = mode_q;
				end else if (c == CH_DOT && mode_q == M_INT) begin
					m1 = M_DOT_INT;
				end else if (c == CH_LOWER_E || c == CH_UPPER_E) begin
					m1 = M_EXP;
				end else begin
					cand_v[0] = 1'b1;
					cand[0]   = mk_span(KIND_NUMBER, tb_q, p);
					cand_v[1] = bt_v;
					cand[1]   = bt_tok;
					m1        = bt_mode;
					tb1       = bt_tb;
				end
			end
			M_DOT_INT: begin
				if (is_digit(c)) begin
					m1 = M_FRAC;
				end else begin
					// The held dot ends the number and is itself an error.
					cand_v[0] = 1'b1;
					cand[0]   = mk_span(KIND_NUMBER, tb_q, pm1);
					cand_v[1] = 1'b1;
					cand[1]   = mk_one(KIND_ERROR, pm1);
					m1        = M_ERROR;
				end
			end
			M_DOT_LEAD: begin
				if (is_digit(c)) begin
					m1 = M_FRAC;
				end else begin
					cand_v[0] = 1'b1;
					cand[0]   = mk_one(KIND_ERROR, tb_q);
					m1        = M_ERROR;
				end
			end
			M_EXP, M_EXP_TAIL: begin
				if (is_digit(c) || (mode_q == M_EXP && (c == CH_PLUS || c == CH_MINUS))) begin
					m1 = M_EXP_TAIL;
				end else begin
					cand_v[0] = 1'b1;
					cand[0]   = mk_span(KIND_NUMBER, tb_q, p);
					cand_v[1] = bt_v;
					cand[1]   = bt_tok;
					m1        = bt_mode;
					tb1       = bt_tb;
				end
			end
			M_IDENT: begin
				if (!is_ident_tail(c)) begin
					cand_v[0] = 1'b1;
					cand[0]   = mk_span(KIND_IDENT, tb_q, p);
					cand_v[1] = bt_v;
					cand[1]   = bt_tok;
					m1        = bt_mode;
					tb1       = bt_tb;
				end
			end
			M_ERROR: begin
				m1 = M_ERROR;
			end
			default: begin
				cand_v[0] = bt_v;
				cand[0]   = bt_tok;
				m1        = bt_mode;
				tb1       = bt_tb;
			end
		endcase

		posn   = (p != '1) ? p + pos_t'(1) : p;
		posnm1 = dec_floor(posn);

		if (item_s1.is_last) begin
			case (m1)
				M_INT, M_FRAC, M_EXP, M_EXP_TAIL: begin
					cand_v[2] = 1'b1;
					cand[2]   = mk_span(KIND_NUMBER, tb1, posn);
				end
				M_DOT_INT: begin
					cand_v[2] = 1'b1;
					cand[2]   = mk_span(KIND_NUMBER, tb1, posnm1);
					cand_v[3] = 1'b1;
					cand[3]   = mk_one(KIND_ERROR, posnm1);
				end
				M_DOT_LEAD: begin
					cand_v[2] = 1'b1;
					cand[2]   = mk_one(KIND_ERROR, tb1);
				end
				M_IDENT: begin
					cand_v[2] = 1'b1;
					cand[2]   = mk_span(KIND_IDENT, tb1, posn);
				end
				default: begin
					cand_v[2] = 1'b0;
				end
			endcase
			cand_v[4] = 1'b1;
			cand[4]   = mk_span(KIND_END, posn, posn);
			mode_d    = M_IDLE;
			pos_d     = '0;
			tb_d      = '0;
		end else begin
			mode_d = m1;
			pos_d  = posn;
			tb_d   = tb1;
		end

		// Pack the produced tokens into the lowest slots, in order.
		slots = '0;
		n     = 2'd0;
		for (int i = 0; i < NUM_CAND; i++) begin
			if (cand_v[i] && n != 2'(MAX_TOKENS)) begin
				slots[n] = cand[i];
				n        = n + 2'd1;
			end
		end
		if (n != 2'd0) begin
			slots[n - 2'd1].last_of_run = 1'b1;
		end

		push.count = adv ? n : 2'd0;
		push.tok   = slots;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pos_q  <= '0;
			tb_q   <= '0;
		end else if (adv) begin
			mode_q <= mode_d;
			pos_q  <= pos_d;
			tb_q   <= tb_d;
		end
	end

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.is_last) |=> (pos_q == '0 && mode_q == M_IDLE && tb_q == '0))
		else $error("scan state not cleared after the final character");

	a_error_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && mode_q == M_ERROR && !item_s1.is_last) |=> (mode_q == M_ERROR))
		else $error("left error mode before the final character");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.is_last) |->
		(push.count != 2'd0 && push.tok[push.count - 2'd1].token_kind == KIND_END))
		else $error("final character did not close with an end token");

endmodule

`default_nettype wire

// File: rtl/core/exlex_tok_fifo.sv
// Token queue of the expression lexer: up to three writes per cycle, one read per cycle.
`default_nettype none

module exlex_tok_fifo import exlex_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       room,
	output logic       token_valid,
	input  wire logic  token_stall,
	output token_t     token_item
);

	token_t [FIFO_DEPTH-1:0] mem_q;
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic pop;

	assign token_valid = (count_q != '0);
	assign token_item  = mem_q[rd_ptr_q];
	assign pop         = token_valid && !token_stall;
	// Room for a full burst, judged on the registered fill level.
	assign room        = (count_q <= CNT_BITS'(FIFO_DEPTH - MAX_TOKENS));

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_TOKENS; i++) begin
			if (2'(i) < push.count) begin
				mem_q[wr_ptr_q + PTR_BITS'(i)] <= push.tok[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_BITS'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			count_q <= count_q + CNT_BITS'(push.count) - CNT_BITS'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count != 2'd0) |-> room)
		else $error("token burst written without room");

	a_ptr_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		((wr_ptr_q - rd_ptr_q) == count_q[PTR_BITS-1:0]) &&
		(count_q <= CNT_BITS'(FIFO_DEPTH)))
		else $error("queue pointers disagree with fill level");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push.count == 2'd0) |=> (count_q == $past(count_q) - CNT_BITS'(1)))
		else $error("fill level did not drop on a read");

endmodule

`default_nettype wire

// File: test/expression_lexer_test.sv
// Self-checking testbench of the expression lexer: directed and random sources against a token predictor.
`default_nettype none

module expression_lexer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import exlex_pkg::*;

	localparam int POS_BITS     = 16;
	localparam int POS_MAX      = (1 << POS_BITS) - 1;
	localparam int RANDOM_CHARS = 400;

	typedef enum logic [3:0] {
		SCAN_IDLE, SCAN_INT, SCAN_DOT_INT, SCAN_DOT_LEAD, SCAN_FRAC,
		SCAN_EXP, SCAN_EXP_TAIL, SCAN_IDENT, SCAN_ERROR
	} scan_mode_t;

	typedef logic [7:0] text_t[$];

	class token_tracker;
		scan_mode_t mode;
		int         pos;
		int         tok_begin;
		token_t     awaited_tokens[$];
		token_t     run[$];
		int         errors;
		int         checked;
		int         kind_hits[16];

		function new();
			clear_scan();
		endfunction

		function void clear_scan();
			mode      = SCAN_IDLE;
			pos       = 0;
			tok_begin = 0;
		endfunction

		function bit digit(logic [7:0] c);
			return c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
		endfunction

		function bit letter(logic [7:0] c);
			return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
		endfunction

		function bit blank(logic [7:0] c);
			return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
		endfunction

		function logic [3:0] punct_kind(logic [7:0] c);
			case (c)
				CH_PLUS:   return KIND_PLUS;
				CH_MINUS:  return KIND_MINUS;
				CH_STAR:   return KIND_STAR;
				CH_SLASH:  return KIND_SLASH;
				CH_CARET:  return KIND_CARET;
				CH_LPAREN: return KIND_LPAREN;
				CH_RPAREN: return KIND_RPAREN;
				CH_COMMA:  return KIND_COMMA;
				default:   return KIND_ERROR;
			endcase
		endfunction

		function int back_one(int p);
			return p > 0 ? p - 1 : 0;
		endfunction

		function void add_token(logic [3:0] kind, int s, int e);
			token_t t;
			int len;
			if (run.size() >= MAX_TOKENS) return;
			len = e >= s ? e - s : 0;
			if (len > 65535) len = 65535;
			t.token_kind   = kind;
			t.token_start  = 16'(s);
			t.token_length = 16'(len);
			t.last_of_run  = 1'b0;
			run.insert(run.size(), t);
		endfunction

		// Called from between tokens: the byte either is skipped, opens a token or is one.
		function void start_token(logic [7:0] c, int p);
			logic [3:0] k;
			k = punct_kind(c);
			mode = SCAN_IDLE;
			if (blank(c)) return;
			tok_begin = p;
			if (digit(c)) mode = SCAN_INT;
			else if (c == CH_DOT) mode = SCAN_DOT_LEAD;
			else if (letter(c) || c == CH_UNDERSCORE) mode = SCAN_IDENT;
			else if (k != KIND_ERROR) add_token(k, p, p + 1);
			else begin
				add_token(KIND_ERROR, p, p + 1);
				mode = SCAN_ERROR;
			end
		endfunction

		function void note_char(char_t ci);
			logic [7:0] c;
			int p;
			c = ci.char_code;
			p = pos;
			run.delete();
			case (mode)
				SCAN_INT, SCAN_FRAC: begin
					if (!digit(c)) begin
						if (c == CH_DOT && mode == SCAN_INT) mode = SCAN_DOT_INT;
						else if (c == CH_LOWER_E || c == CH_UPPER_E) mode = SCAN_EXP;
						else begin
							add_token(KIND_NUMBER, tok_begin, p);
							start_token(c, p);
						end
					end
				end
				SCAN_DOT_INT: begin
					if (digit(c)) mode = SCAN_FRAC;
					else begin
						add_token(KIND_NUMBER, tok_begin, back_one(p));
						add_token(KIND_ERROR, back_one(p), back_one(p) + 1);
						mode = SCAN_ERROR;
					end
				end
				SCAN_DOT_LEAD: begin
					if (digit(c)) mode = SCAN_FRAC;
					else begin
						add_token(KIND_ERROR, tok_begin, tok_begin + 1);
						mode = SCAN_ERROR;
					end
				end
				SCAN_EXP: begin
					if (digit(c) || c == CH_PLUS || c == CH_MINUS) mode = SCAN_EXP_TAIL;
					else begin
						add_token(KIND_NUMBER, tok_begin, p);
						start_token(c, p);
					end
				end
				SCAN_EXP_TAIL: begin
					if (!digit(c)) begin
						add_token(KIND_NUMBER, tok_begin, p);
						start_token(c, p);
					end
				end
				SCAN_IDENT: begin
					if (!(letter(c) || digit(c) || c == CH_UNDERSCORE)) begin
						add_token(KIND_IDENT, tok_begin, p);
						start_token(c, p);
					end
				end
				SCAN_ERROR: ;
				default: start_token(c, p);
			endcase
			pos = p < POS_MAX ? p + 1 : POS_MAX;
			if (ci.is_last) begin
				case (mode)
					SCAN_INT, SCAN_FRAC, SCAN_EXP, SCAN_EXP_TAIL:
						add_token(KIND_NUMBER, tok_begin, pos);
					SCAN_DOT_INT: begin
						add_token(KIND_NUMBER, tok_begin, back_one(pos));
						add_token(KIND_ERROR, back_one(pos), back_one(pos) + 1);
					end
					SCAN_DOT_LEAD: add_token(KIND_ERROR, tok_begin, tok_begin + 1);
					SCAN_IDENT:    add_token(KIND_IDENT, tok_begin, pos);
					default: ;
				endcase
				add_token(KIND_END, pos, pos);
				clear_scan();
			end
			if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
			foreach (run[i]) awaited_tokens.insert(awaited_tokens.size(), run[i]);
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				errors++;
				$display("%0t: token %s mismatch, expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_token(token_t got);
			token_t want;
			if (awaited_tokens.size() == 0) begin
				errors++;
				$display("%0t: unexpected token, expected none, got kind %0d start %0d length %0d",
					$time, got.token_kind, got.token_start, got.token_length);
				return;
			end
			want = awaited_tokens.pop_front();
			checked++;
			kind_hits[want.token_kind]++;
			compare_field("kind", want.token_kind, got.token_kind);
			compare_field("start", want.token_start, got.token_start);
			compare_field("length", want.token_length, got.token_length);
			compare_field("last_of_run", want.last_of_run, got.last_of_run);
		endfunction

		function int pending();
			return awaited_tokens.size();
		endfunction
	endclass

	logic   clk = 1'b0;
	logic   arst_n;
	logic   char_valid;
	logic   char_stall;
	char_t  char_item;
	logic   token_valid;
	logic   token_stall;
	token_t token_item;

	token_tracker sb = new();
	text_t        src;
	bit           quiet;
	int           chars_sent;
	int           sources_sent;

	always #1 clk = ~clk;

	expression_lexer #(
		.POSITION_BITS(POS_BITS)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token_item (token_item)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if (char_valid && !char_stall) sb.note_char(char_item);
			if (token_valid && !token_stall) sb.check_token(token_item);
		end
	end

	// Mostly no pause, often a short one, now and then a long one.
	function automatic int pause_len();
		int r;
		if (quiet) return 0;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	initial begin : token_sink
		int hold;
		token_stall <= 1'b0;
		forever begin
			@(posedge clk);
			hold = pause_len();
			if (hold > 0) begin
				token_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				token_stall <= 1'b0;
			end
		end
	end

	function automatic void append_byte(logic [7:0] b);
		src.insert(src.size(), b);
	endfunction

	function automatic void add_digits(int lo, int hi);
		int n;
		n = $urandom_range(hi, lo);
		repeat (n) append_byte(8'(CH_DIGIT_0 + $urandom_range(9)));
	endfunction

	function automatic logic [7:0] random_letter();
		return 8'(($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A) + $urandom_range(25));
	endfunction

	function automatic void add_number();
		if ($urandom_range(99) < 8) begin
			// A leading dot, sometimes with no digit after it.
			append_byte(CH_DOT);
			add_digits(0, 3);
		end else begin
			add_digits(1, 4);
			case ($urandom_range(9))
				0, 1, 2: begin
					append_byte(CH_DOT);
					add_digits(1, 3);
				end
				3: append_byte(CH_DOT);
				default: ;
			endcase
		end
		if ($urandom_range(99) < 25) begin
			append_byte($urandom_range(1) ? CH_LOWER_E : CH_UPPER_E);
			case ($urandom_range(2))
				0: append_byte(CH_PLUS);
				1: append_byte(CH_MINUS);
				default: ;
			endcase
			add_digits(0, 2);
		end
	endfunction

	function automatic void add_ident();
		int n;
		append_byte($urandom_range(9) == 0 ? CH_UNDERSCORE : random_letter());
		n = $urandom_range(5);
		repeat (n) begin
			case ($urandom_range(5))
				0: append_byte(CH_UNDERSCORE);
				1, 2: append_byte(8'(CH_DIGIT_0 + $urandom_range(9)));
				default: append_byte(random_letter());
			endcase
		end
	endfunction

	function automatic logic [7:0] random_op();
		case ($urandom_range(7))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_STAR;
			3: return CH_SLASH;
			4: return CH_CARET;
			5: return CH_LPAREN;
			6: return CH_RPAREN;
			default: return CH_COMMA;
		endcase
	endfunction

	function automatic logic [7:0] random_blank();
		return $urandom_range(1) ? CH_SPACE : 8'(CH_TAB + $urandom_range(4));
	endfunction

	// Mostly well-formed expressions; a few stray bytes break some of them.
	function automatic void build_source();
		int pieces;
		int r;
		src.delete();
		pieces = $urandom_range(8, 1);
		repeat (pieces) begin
			r = $urandom_range(99);
			if (r < 35) add_number();
			else if (r < 60) add_ident();
			else if (r < 85) append_byte(random_op());
			else if (r < 96) append_byte(random_blank());
			else append_byte(8'($urandom_range(255)));
		end
	endfunction

	task automatic send_char(input char_t c);
		char_item  <= c;
		char_valid <= 1'b1;
		do @(posedge clk); while (char_stall);
		chars_sent++;
	endtask

	task automatic send_source();
		char_t c;
		int gap;
		foreach (src[i]) begin
			c.char_code = src[i];
			c.is_last   = (i == src.size() - 1);
			send_char(c);
			gap = pause_len();
			if (gap > 0) begin
				char_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		sources_sent++;
	endtask

	task automatic send_text(input string s);
		src.delete();
		for (int i = 0; i < s.len(); i++) append_byte(s[i]);
		send_source();
	endtask

	// One edge first so the last accepted character is already in the predictor.
	task automatic drain();
		char_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		int random_chars;
		int kinds;
		arst_n     <= 1'b0;
		char_valid <= 1'b0;
		char_item  <= '0;
		quiet = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every operator, identifiers, a leading-dot fraction and an exponent.
		send_text("_9+(.5E2)*a/b^c,1-");
		// Exponent with no digits, then a lone dot.
		send_text("1e");
		send_text(". ");
		// Unexpected bytes at both ends of the range; the second is ignored.
		src.delete();
		append_byte(8'hFF);
		append_byte(8'h00);
		send_source();
		drain();

		random_chars = 0;
		while (random_chars < RANDOM_CHARS) begin
			quiet = ($urandom_range(99) < 15);
			build_source();
			random_chars += src.size();
			send_source();
		end
		quiet = 1'b0;
		drain();
		repeat (10) @(posedge clk);

		kinds = 0;
		for (int k = 0; k < 16; k++) if (sb.kind_hits[k] > 0) kinds++;
		$display("Covered %0d sources and %0d characters, with stalls on both sides.",
			sources_sent, chars_sent);
		$display("Checked %0d tokens spanning %0d of 12 token kinds, %0d mismatches.",
			sb.checked, kinds, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("expression_lexer_test: PASS");
		end else begin
			$display("expression_lexer_test: FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("expression_lexer_test: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
